// File: src/g2l_pkg.sv
// Package with the shared types, codes and character map of the Greek-to-Latin transliterator.
package g2l_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned MaxOut = 4;
  localparam int unsigned CntW = 3;
  localparam int unsigned HiBase = 180;
  localparam int unsigned HiDepth = 76;

  typedef enum logic [2:0] {
    PendNone = 3'd0,
    PendUM   = 3'd1,
    PendLM   = 3'd2,
    PendUN   = 3'd3,
    PendLN   = 3'd4
  } pend_e;

  typedef struct packed {
    logic [MaxOut-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]              count;
  } burst_t;

  localparam logic [ByteW-1:0] CodeUM    = 8'd204;
  localparam logic [ByteW-1:0] CodeLM    = 8'd236;
  localparam logic [ByteW-1:0] CodeUN    = 8'd205;
  localparam logic [ByteW-1:0] CodeLN    = 8'd237;
  localparam logic [ByteW-1:0] CodeUPi   = 8'd208;
  localparam logic [ByteW-1:0] CodeLPi   = 8'd240;
  localparam logic [ByteW-1:0] CodeUTau  = 8'd212;
  localparam logic [ByteW-1:0] CodeLTau  = 8'd244;
  localparam logic [ByteW-1:0] CharUB    = 8'h42;
  localparam logic [ByteW-1:0] CharLB    = 8'h62;
  localparam logic [ByteW-1:0] CharUD    = 8'h44;
  localparam logic [ByteW-1:0] CharLD    = 8'h64;

  localparam logic [23:0] HiRom [HiDepth] = '{
    24'h000027, 24'h002722, 24'h004127, 24'h0000B7,
    24'h004527, 24'h004827, 24'h004927, 24'h0000BB,
    24'h004F27, 24'h0000BD, 24'h005927, 24'h005727,
    24'h222769, 24'h000041, 24'h000056, 24'h000047,
    24'h000044, 24'h000045, 24'h00005A, 24'h000048,
    24'h000038, 24'h000049, 24'h00004B, 24'h00004C,
    24'h00004D, 24'h00004E, 24'h00534B, 24'h00004F,
    24'h000050, 24'h000052, 24'h000000, 24'h000053,
    24'h000054, 24'h000059, 24'h000046, 24'h000058,
    24'h005350, 24'h000057, 24'h002249, 24'h002259,
    24'h002761, 24'h002765, 24'h002768, 24'h002769,
    24'h222779, 24'h000061, 24'h000076, 24'h000067,
    24'h000064, 24'h000065, 24'h00007A, 24'h000068,
    24'h000038, 24'h000069, 24'h00006B, 24'h00006C,
    24'h00006D, 24'h00006E, 24'h00736B, 24'h00006F,
    24'h000070, 24'h000072, 24'h000073, 24'h000073,
    24'h000074, 24'h000079, 24'h000066, 24'h000078,
    24'h007370, 24'h000077, 24'h002269, 24'h002279,
    24'h00276F, 24'h002779, 24'h002777, 24'h000000
  };

  function automatic logic [23:0] char_map(input logic [ByteW-1:0] code);
    logic [ByteW-1:0] off;
    off = code - ByteW'(HiBase);
    if (code < ByteW'(HiBase)) begin
      return {16'h0000, code};
    end
    return HiRom[off[6:0]];
  endfunction

  function automatic logic [ByteW-1:0] pend_char(input pend_e p);
    case (p)
      PendUM:  return 8'h4D;
      PendLM:  return 8'h6D;
      PendUN:  return 8'h4E;
      PendLN:  return 8'h6E;
      default: return 8'h00;
    endcase
  endfunction

  function automatic pend_e hold_code(input logic [ByteW-1:0] code);
    case (code)
      CodeUM:  return PendUM;
      CodeLM:  return PendLM;
      CodeUN:  return PendUN;
      CodeLN:  return PendLN;
      default: return PendNone;
    endcase
  endfunction

endpackage

// File: src/g2l_mapper.sv
// Combinational mapper that turns one input code and the held letter into a burst of bytes.
module g2l_mapper (
  input  logic                   action_i,
  input  logic [7:0]             in_byte_i,
  input  g2l_pkg::pend_e         pend_i,
  output g2l_pkg::pend_e         pend_next_o,
  output g2l_pkg::burst_t        burst_o
);
  import g2l_pkg::*;

  logic [ByteW-1:0]             prefix;
  logic                         prefix_vld;
  logic [23:0]                  entry;
  pend_e                        held;
  logic [MaxOut-1:0][ByteW-1:0] cand;
  logic [MaxOut-1:0]            cand_vld;

  always_comb begin
    held        = hold_code(in_byte_i);
    prefix      = pend_char(pend_i);
    prefix_vld  = (pend_i != PendNone);
    entry       = 24'h000000;
    pend_next_o = PendNone;
    if (action_i) begin
      entry = 24'h000000;
    end else if ((pend_i inside {PendUM, PendLM}) && (in_byte_i inside {CodeUPi, CodeLPi})) begin
      prefix = (pend_i == PendUM) ? CharUB : CharLB;
    end else if ((pend_i inside {PendUN, PendLN}) &&
                 (in_byte_i inside {CodeUTau, CodeLTau})) begin
      prefix = (pend_i == PendUN) ? CharUD : CharLD;
    end else if (held != PendNone) begin
      pend_next_o = held;
    end else begin
      entry = char_map(in_byte_i);
    end
  end

  always_comb begin
    logic [CntW-1:0] cnt;
    cand[0]     = prefix;
    cand_vld[0] = prefix_vld;
    for (int k = 1; k < MaxOut; k++) begin
      cand[k]     = entry[8*(k-1) +: 8];
      cand_vld[k] = (entry[8*(k-1) +: 8] != 8'h00);
    end
    cnt           = '0;
    burst_o.bytes = '0;
    for (int k = 0; k < MaxOut; k++) begin
      if (cand_vld[k]) begin
        burst_o.bytes[cnt[1:0]] = cand[k];
        cnt = cnt + CntW'(1);
      end
    end
    burst_o.count = cnt;
  end

endmodule

// File: src/greek_to_latin_transliterator_core.sv
// Top level of the ISO-8859-7 to Latin transliterator with input register and output serializer.
//
// Each input transfer on the s_axis channel carries one ISO-8859-7 code in
// tdata and the end-of-stream flag in tuser. The block answers with zero to
// four Latin-1 bytes on the m_axis channel, one byte per transfer, and tlast
// marks the final byte caused by one input item.
// An accepted item is held in the input register, is mapped by short logic,
// and its bytes are loaded into the output register, which holds up to four
// bytes and shifts them out one per transfer; an item that yields no bytes
// leaves it empty. A new item is accepted while the last byte of the previous
// one is being sent.
// The letters M, m, N and n are held until the next item decides whether they
// merge with a following pi or tau; an end-of-stream item releases them.
// Reset clears the held letter and empties both registers.
// When the receiver stalls, the current byte holds, and the input side stops
// once the input register is full.
module greek_to_latin_transliterator_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tuser_i,   // [0] action
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o
);
  import g2l_pkg::*;

  logic                         in_vld_q;
  logic                         in_action_q;
  logic [ByteW-1:0]             in_byte_q;
  pend_e                        pend_q;
  pend_e                        pend_d;
  logic [CntW-1:0]              out_cnt_q;
  logic [CntW-1:0]              out_cnt_d;
  logic [MaxOut-1:0][ByteW-1:0] out_bytes_q;
  logic [MaxOut-1:0][ByteW-1:0] out_bytes_d;
  burst_t                       burst;
  logic                         in_take;
  logic                         out_take;
  logic                         out_free;
  logic                         consume;

  g2l_mapper u_mapper (
    .action_i    (in_action_q),
    .in_byte_i   (in_byte_q),
    .pend_i      (pend_q),
    .pend_next_o (pend_d),
    .burst_o     (burst)
  );

  assign m_axis_tvalid_o = (out_cnt_q != '0);
  assign m_axis_tdata_o  = out_bytes_q[0];
  assign m_axis_tlast_o  = (out_cnt_q == CntW'(1));
  assign out_take        = m_axis_tvalid_o && m_axis_tready_i;
  assign out_free        = (out_cnt_q == '0) || (m_axis_tlast_o && m_axis_tready_i);
  assign consume         = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || consume;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    out_cnt_d   = out_cnt_q;
    out_bytes_d = out_bytes_q;
    if (consume) begin
      out_cnt_d   = burst.count;
      out_bytes_d = burst.bytes;
    end else if (out_take) begin
      out_cnt_d   = out_cnt_q - CntW'(1);
      out_bytes_d = {8'h00, out_bytes_q[MaxOut-1:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      pend_q    <= PendNone;
      out_cnt_q <= '0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (consume) begin
        in_vld_q <= 1'b0;
      end
      if (consume) begin
        pend_q <= pend_d;
      end
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_action_q <= s_axis_tuser_i;
      in_byte_q   <= s_axis_tdata_i;
    end
    out_bytes_q <= out_bytes_d;
  end

endmodule

// File: src/g2l_checker.sv
// Port-level checker for the transliterator top level and its bind statement.
module g2l_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("Stalled output transfer changed.");

  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=> m_axis_tvalid_o)
    else $error("Burst broke off before its last byte.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("Input stalled while the output side is empty.");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("Output valid right after reset.");

endmodule

bind greek_to_latin_transliterator_core g2l_checker u_g2l_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
